### src/c2cs_pkg.sv
package c2cs_pkg;

    localparam int CORDIC_STAGES = 24;

    // Q1.30 CORDIC start value (gain compensated) and unity
    localparam logic [33:0] GAIN_Q30 = 34'd652032874;
    localparam logic [33:0] ONE_Q30  = 34'd1073741824;

    // Register map: index of each register, decoded from paddr[2]
    localparam logic       REG_VELOCITY_SCALE = 1'b0;
    localparam logic [31:0] VELOCITY_SCALE_RST = 32'd1382485;

    // atan(2^-i) in 2^32-per-turn units
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Sine and cosine in sign-magnitude form, magnitude at most 2^30
    typedef struct packed {
        logic [30:0] cos_mag;
        logic        cos_neg;
        logic [30:0] sin_mag;
        logic        sin_neg;
    } t_trig;

endpackage

### src/c2cs_cordic.sv
module c2cs_cordic (
    input  logic                                i_clk,
    input  logic [c2cs_pkg::CORDIC_STAGES+1:0]  i_en,
    input  logic [31:0]                         i_angle,
    output c2cs_pkg::t_trig                     o_trig
);

    localparam int CS = c2cs_pkg::CORDIC_STAGES;

    logic signed [33:0] r_x [CS+1];
    logic signed [33:0] r_y [CS+1];
    logic signed [33:0] r_z [CS+1];
    logic [1:0]         r_q [CS+1];

    logic [31:0] n_turn;
    logic [1:0]  n_q;
    logic [31:0] n_res;

    // Split into quadrant and a residual in [-1/8, 1/8) turn
    always_comb begin
        n_turn = i_angle + 32'h2000_0000;
        n_q    = n_turn[31:30];
        n_res  = i_angle - {n_q, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0] <= c2cs_pkg::GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= {{2{n_res[31]}}, n_res};
            r_q[0] <= n_q;
        end
    end

    for (genvar j = 1; j <= CS; j++) begin : g_iter
        logic [33:0] w_atan;
        assign w_atan = {2'b00, c2cs_pkg::ATAN_TURN[j-1]};
        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_q[j] <= r_q[j-1];
                if (r_z[j-1] >= 0) begin
                    r_x[j] <= r_x[j-1] - (r_y[j-1] >>> (j-1));
                    r_y[j] <= r_y[j-1] + (r_x[j-1] >>> (j-1));
                    r_z[j] <= r_z[j-1] - $signed(w_atan);
                end else begin
                    r_x[j] <= r_x[j-1] + (r_y[j-1] >>> (j-1));
                    r_y[j] <= r_y[j-1] - (r_x[j-1] >>> (j-1));
                    r_z[j] <= r_z[j-1] + $signed(w_atan);
                end
            end
        end
    end

    logic signed [33:0] n_xc, n_yc;
    logic [30:0]        n_xm, n_ym;
    logic               n_xn, n_xp, n_yn, n_yp;
    c2cs_pkg::t_trig    n_trig;

    // Clamp to unity, then fold the quadrant back in
    always_comb begin
        if (r_x[CS] > $signed(c2cs_pkg::ONE_Q30)) n_xc = $signed(c2cs_pkg::ONE_Q30);
        else if (r_x[CS] < -$signed(c2cs_pkg::ONE_Q30)) n_xc = -$signed(c2cs_pkg::ONE_Q30);
        else n_xc = r_x[CS];
        if (r_y[CS] > $signed(c2cs_pkg::ONE_Q30)) n_yc = $signed(c2cs_pkg::ONE_Q30);
        else if (r_y[CS] < -$signed(c2cs_pkg::ONE_Q30)) n_yc = -$signed(c2cs_pkg::ONE_Q30);
        else n_yc = r_y[CS];
        n_xn = n_xc < 0;
        n_xp = n_xc > 0;
        n_yn = n_yc < 0;
        n_yp = n_yc > 0;
        n_xm = n_xn ? 31'(-n_xc) : 31'(n_xc);
        n_ym = n_yn ? 31'(-n_yc) : 31'(n_yc);
        case (r_q[CS])
            2'd0: begin
                n_trig = '{cos_mag: n_xm, cos_neg: n_xn, sin_mag: n_ym, sin_neg: n_yn};
            end
            2'd1: begin
                n_trig = '{cos_mag: n_ym, cos_neg: n_yp, sin_mag: n_xm, sin_neg: n_xn};
            end
            2'd2: begin
                n_trig = '{cos_mag: n_xm, cos_neg: n_xp, sin_mag: n_ym, sin_neg: n_yp};
            end
            default: begin
                n_trig = '{cos_mag: n_ym, cos_neg: n_yn, sin_mag: n_xm, sin_neg: n_xp};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[CS+1]) begin
            o_trig <= n_trig;
        end
    end

endmodule

### src/catalog_to_cartesian_state.sv
// Each input transfer passes through capture, the CORDIC stages and the named stages below to the output register.
// Throughput: one catalog entry per cycle while m_tready keeps up; every stage advances on its own, so bubbles close
// up and, while some stage is empty, a new entry is taken as a finished result waits in the output register.
// Depth is set by the two unrolled CORDIC pipelines, one rotation per stage.
// Reset (synchronous, active low) empties the pipeline and sets velocity_scale to 1382485.
module catalog_to_cartesian_state (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB-style register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // catalog entry in
    input  logic         s_tvalid,
    output logic         s_tready,
    // right_ascension, declination, ra_rate, dec_rate, parallax, radial_velocity
    input  logic [191:0] s_tdata,
    // state vector out
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic [191:0] m_tdata
);

    localparam int CS       = c2cs_pkg::CORDIC_STAGES;
    localparam int ST_TRIG  = CS + 2;   // sine/cosine ready
    localparam int ST_PROD  = CS + 3;   // direction products
    localparam int ST_MUL   = CS + 4;   // rate products
    localparam int ST_COMB  = CS + 5;   // shift and join partial products
    localparam int ST_SUM   = CS + 6;   // signed sums
    localparam int ST_OUT   = CS + 7;   // saturate into output register

    typedef struct packed {
        logic [31:0] rd_mag;
        logic        rd_neg;
        logic [31:0] dd_mag;
        logic        dd_neg;
        logic        rv_neg;
    } t_side;

    // Give a magnitude the sign it carries
    function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
        apply_sign = neg ? -$signed(m) : $signed(m);
    endfunction

    // ---------------------------------------------------------------- registers
    logic [31:0] r_k;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr[2] == c2cs_pkg::REG_VELOCITY_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= c2cs_pkg::VELOCITY_SCALE_RST;
        end else if (w_wr) begin
            r_k <= pwdata;
        end
    end

    assign prdata = (paddr[2] == c2cs_pkg::REG_VELOCITY_SCALE) ? r_k : 32'd0;

    // ---------------------------------------------------------------- flow control
    // A stage may load when it is empty or when the stage after it loads too.
    logic [ST_OUT:0] r_vld;
    logic [ST_OUT:0] w_en;

    always_comb begin
        w_en[ST_OUT] = !r_vld[ST_OUT] || m_tready;
        for (int s = ST_OUT - 1; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign s_tready = w_en[0];
    assign m_tvalid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_tvalid;
            end
            for (int s = 1; s <= ST_OUT; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------- stage 0: capture
    logic [31:0] w_ra, w_dec, w_rd, w_dd, w_px, w_rv;
    assign w_ra  = s_tdata[31:0];
    assign w_dec = s_tdata[63:32];
    assign w_rd  = s_tdata[95:64];
    assign w_dd  = s_tdata[127:96];
    assign w_px  = s_tdata[159:128];
    assign w_rv  = s_tdata[191:160];

    logic [31:0] r_ra, r_dec, r_px, r_rv_mag;
    t_side       r_side [ST_MUL];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ra            <= w_ra;
            r_dec           <= w_dec;
            r_px            <= w_px;
            r_rv_mag        <= w_rv[31] ? (~w_rv + 32'd1) : w_rv;
            r_side[0].rd_mag <= w_rd[31] ? (~w_rd + 32'd1) : w_rd;
            r_side[0].rd_neg <= w_rd[31];
            r_side[0].dd_mag <= w_dd[31] ? (~w_dd + 32'd1) : w_dd;
            r_side[0].dd_neg <= w_dd[31];
            r_side[0].rv_neg <= w_rv[31];
        end
    end

    // Carry the proper motions alongside the CORDIC
    for (genvar s = 1; s < ST_MUL; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // ---------------------------------------------------------------- sine and cosine
    c2cs_pkg::t_trig w_tra, w_tdec;

    c2cs_cordic u_cordic_ra (
        .i_clk   (i_clk),
        .i_en    (w_en[ST_TRIG:1]),
        .i_angle (r_ra),
        .o_trig  (w_tra)
    );

    c2cs_cordic u_cordic_dec (
        .i_clk   (i_clk),
        .i_en    (w_en[ST_TRIG:1]),
        .i_angle (r_dec),
        .o_trig  (w_tdec)
    );

    // ---------------------------------------------------------------- f = k*rv*px >> 40
    logic [63:0] r_kv;
    logic [31:0] r_px1;
    logic [63:0] r_fh, r_fl;
    logic [54:0] r_fmag [CS+1];
    logic [64:0] w_fsum;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_kv  <= 64'(r_k) * 64'(r_rv_mag);
            r_px1 <= r_px;
        end
        if (w_en[2]) begin
            r_fh <= 64'(r_kv[63:32]) * 64'(r_px1);
            r_fl <= 64'(r_kv[31:0]) * 64'(r_px1);
        end
    end

    assign w_fsum = 65'(r_fh) + 65'(r_fl[63:32]);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_fmag[0] <= w_fsum[62:8];
        end
    end

    for (genvar s = 1; s <= CS; s++) begin : g_f
        always_ff @(posedge i_clk) begin
            if (w_en[s+3]) begin
                r_fmag[s] <= r_fmag[s-1];
            end
        end
    end

    // ---------------------------------------------------------------- direction products
    logic [61:0] w_pcc, w_psc, w_pcs, w_pss;
    logic [30:0] r_cc, r_sc, r_cs, r_ss, r_sd, r_cd;
    logic        r_cc_n, r_sc_n, r_cs_n, r_ss_n, r_sd_n, r_cd_n;

    assign w_pcc = 62'(w_tra.cos_mag) * 62'(w_tdec.cos_mag);
    assign w_psc = 62'(w_tra.sin_mag) * 62'(w_tdec.cos_mag);
    assign w_pcs = 62'(w_tra.cos_mag) * 62'(w_tdec.sin_mag);
    assign w_pss = 62'(w_tra.sin_mag) * 62'(w_tdec.sin_mag);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            r_cc   <= w_pcc[60:30];
            r_sc   <= w_psc[60:30];
            r_cs   <= w_pcs[60:30];
            r_ss   <= w_pss[60:30];
            r_cc_n <= w_tra.cos_neg ^ w_tdec.cos_neg;
            r_sc_n <= w_tra.sin_neg ^ w_tdec.cos_neg;
            r_cs_n <= w_tra.cos_neg ^ w_tdec.sin_neg;
            r_ss_n <= w_tra.sin_neg ^ w_tdec.sin_neg;
            r_sd   <= w_tdec.sin_mag;
            r_sd_n <= w_tdec.sin_neg;
            r_cd   <= w_tdec.cos_mag;
            r_cd_n <= w_tdec.cos_neg;
        end
    end

    // ---------------------------------------------------------------- rate products
    // Terms: 0 ra_rate*sc, 1 dec_rate*cs, 2 f*cc, 3 ra_rate*cc, 4 dec_rate*ss,
    // 5 f*sc, 6 dec_rate*cd, 7 f*sd. Neg bits already fold in the subtractions.
    t_side       w_sd;
    logic [22:0] w_fhi;
    logic [31:0] w_flo;
    logic [62:0] r_pm [8];   // direct products, or low halves of f products
    logic [53:0] r_ph [8];   // high halves of f products
    logic [7:0]  r_pn;
    logic [31:0] r_pos_m [3];

    assign w_sd  = r_side[ST_PROD];
    assign w_fhi = r_fmag[CS][54:32];
    assign w_flo = r_fmag[CS][31:0];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            r_pm[0] <= 63'(w_sd.rd_mag) * 63'(r_sc);
            r_pm[1] <= 63'(w_sd.dd_mag) * 63'(r_cs);
            r_pm[2] <= 63'(w_flo) * 63'(r_cc);
            r_pm[3] <= 63'(w_sd.rd_mag) * 63'(r_cc);
            r_pm[4] <= 63'(w_sd.dd_mag) * 63'(r_ss);
            r_pm[5] <= 63'(w_flo) * 63'(r_sc);
            r_pm[6] <= 63'(w_sd.dd_mag) * 63'(r_cd);
            r_pm[7] <= 63'(w_flo) * 63'(r_sd);
            r_ph[0] <= '0;
            r_ph[1] <= '0;
            r_ph[2] <= 54'(w_fhi) * 54'(r_cc);
            r_ph[3] <= '0;
            r_ph[4] <= '0;
            r_ph[5] <= 54'(w_fhi) * 54'(r_sc);
            r_ph[6] <= '0;
            r_ph[7] <= 54'(w_fhi) * 54'(r_sd);
            r_pn[0] <= !(w_sd.rd_neg ^ r_sc_n);
            r_pn[1] <= !(w_sd.dd_neg ^ r_cs_n);
            r_pn[2] <= w_sd.rv_neg ^ r_cc_n;
            r_pn[3] <= w_sd.rd_neg ^ r_cc_n;
            r_pn[4] <= !(w_sd.dd_neg ^ r_ss_n);
            r_pn[5] <= w_sd.rv_neg ^ r_sc_n;
            r_pn[6] <= w_sd.dd_neg ^ r_cd_n;
            r_pn[7] <= w_sd.rv_neg ^ r_sd_n;
            r_pos_m[0] <= r_cc_n ? -{1'b0, r_cc} : {1'b0, r_cc};
            r_pos_m[1] <= r_sc_n ? -{1'b0, r_sc} : {1'b0, r_sc};
            r_pos_m[2] <= r_sd_n ? -{1'b0, r_sd} : {1'b0, r_sd};
        end
    end

    // ---------------------------------------------------------------- join partials
    logic signed [63:0] r_t [8];
    logic [31:0]        r_pos_c [3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_COMB]) begin
            for (int t = 0; t < 8; t++) begin
                r_t[t] <= apply_sign({r_ph[t], 2'b00} + 64'(r_pm[t][62:30]), r_pn[t]);
            end
            r_pos_c <= r_pos_m;
        end
    end

    // ---------------------------------------------------------------- sums
    logic signed [63:0] r_vx, r_vy, r_vz;
    logic [31:0]        r_pos_s [3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_vx    <= r_t[0] + r_t[1] + r_t[2];
            r_vy    <= r_t[3] + r_t[4] + r_t[5];
            r_vz    <= r_t[6] + r_t[7];
            r_pos_s <= r_pos_c;
        end
    end

    // ---------------------------------------------------------------- saturate and hold
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) sat32 = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) sat32 = 32'h8000_0000;
        else sat32 = v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            m_tdata <= {sat32(r_vz), sat32(r_vy), sat32(r_vx),
                        r_pos_s[2], r_pos_s[1], r_pos_s[0]};
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY = c2cs_pkg::CORDIC_STAGES + 8;
    localparam logic [2:0] ADDR_SCALE = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    typedef struct packed {
        logic [31:0] radial_velocity;
        logic [31:0] parallax;
        logic [31:0] dec_rate;
        logic [31:0] ra_rate;
        logic [31:0] declination;
        logic [31:0] right_ascension;
    } t_catalog_entry;

    typedef struct packed {
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_state_vec;

    logic         i_clk;
    logic         i_rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    // right_ascension, declination, ra_rate, dec_rate, parallax, radial_velocity
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    logic [191:0] m_tdata;

    // expected state vectors, oldest first
    t_state_vec   pending_states[$];
    logic [31:0]  scale_k;
    int           error_count;
    int           entries_sent;
    int           states_seen;
    // when set, both sides run without gaps or stalls
    bit           steady;
    int           rx_hold;

    catalog_to_cartesian_state u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // truncating product of magnitudes, sign restored afterwards
    function automatic longint scaled_product(input longint a, input longint b, input int sh);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        logic [63:0]  m;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ma} * {64'd0, mb};
        m = 64'(p >> sh);
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // rotation-mode CORDIC with quadrant folding
    function automatic void sin_cos_q30(input logic [31:0] angle,
                                        output longint c, output longint s);
        logic [31:0] quad;
        logic [31:0] resid;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        quad  = ((angle + 32'h2000_0000) >> 30) & 32'd3;
        resid = angle - (quad << 30);
        z = longint'($signed(resid));
        x = longint'(c2cs_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < c2cs_pkg::CORDIC_STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(c2cs_pkg::ATAN_TURN[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(c2cs_pkg::ATAN_TURN[i]);
            end
            x = nx;
        end
        x = clip(x, -longint'(c2cs_pkg::ONE_Q30), longint'(c2cs_pkg::ONE_Q30));
        y = clip(y, -longint'(c2cs_pkg::ONE_Q30), longint'(c2cs_pkg::ONE_Q30));
        case (quad[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [31:0] sat_q824(input longint v);
        return 32'(clip(v, -longint'(64'sh8000_0000), 64'sh7FFF_FFFF));
    endfunction

    function automatic t_state_vec predict_state(input t_catalog_entry e, input logic [31:0] k);
        t_state_vec r;
        longint cr, sr, cd, sd, cc, sc, cs, ss, rd, dd, rv, px, f, vx, vy, vz;
        sin_cos_q30(e.right_ascension, cr, sr);
        sin_cos_q30(e.declination, cd, sd);
        rd = longint'($signed(e.ra_rate));
        dd = longint'($signed(e.dec_rate));
        px = longint'({32'd0, e.parallax});
        rv = longint'($signed(e.radial_velocity));
        cc = scaled_product(cr, cd, 30);
        sc = scaled_product(sr, cd, 30);
        cs = scaled_product(cr, sd, 30);
        ss = scaled_product(sr, sd, 30);
        f  = scaled_product(longint'({32'd0, k}) * rv, px, 40);
        vx = -scaled_product(rd, sc, 30) - scaled_product(dd, cs, 30)
             + scaled_product(f, cc, 30);
        vy = scaled_product(rd, cc, 30) - scaled_product(dd, ss, 30)
             + scaled_product(f, sc, 30);
        vz = scaled_product(dd, cd, 30) + scaled_product(f, sd, 30);
        r.pos_x = 32'(cc);
        r.pos_y = 32'(sc);
        r.pos_z = 32'(sd);
        r.vel_x = sat_q824(vx);
        r.vel_y = sat_q824(vy);
        r.vel_z = sat_q824(vz);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Send one catalog entry; valid stays high into the next call unless a gap is drawn.
    task automatic send_entry(input t_catalog_entry e);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= e;
        do @(posedge i_clk); while (!s_tready);
        pending_states.push_back(predict_state(e, scale_k));
        entries_sent++;
    endtask

    // Drop valid and hold until every expected state vector has come back.
    task automatic drain;
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_states.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Write one register, then read back velocity_scale; any address with paddr[2] clear maps to it.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] want;
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_SCALE) scale_k = value;
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0; paddr <= ADDR_SCALE;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = scale_k;
        if (prdata !== want) begin
            $display("%0t: velocity_scale readback expected %h actual %h", $time, want, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic t_catalog_entry random_entry;
        t_catalog_entry e;
        e.right_ascension = $urandom;
        // mostly legal declinations, some beyond the pole
        e.declination = ($urandom_range(0, 9) == 0) ? $urandom
                      : 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        case ($urandom_range(0, 3))
            0: begin
                e.ra_rate = $urandom;
                e.dec_rate = $urandom;
                e.parallax = $urandom;
                e.radial_velocity = $urandom;
            end
            default: begin
                // realistic star: small motions, small parallax, moderate velocity
                e.ra_rate = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
                e.dec_rate = 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
                e.parallax = $urandom >> $urandom_range(0, 24);
                e.radial_velocity = 32'($signed($urandom_range(0, 32'h0400_0000))
                                    - 32'sh0200_0000);
            end
        endcase
        return e;
    endfunction

    // ---------------------------------------------------------------
    // Response side: stall at random, compare each transfer field by field
    // ---------------------------------------------------------------

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_state_vec got;
        t_state_vec want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            states_seen++;
            rx_hold = steady ? 0 : $urandom_range(0, 11);
            if (pending_states.size() == 0) begin
                $display("%0t: unexpected state vector %h", $time, got);
                error_count++;
            end else begin
                want = pending_states.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $display("%0t: pos_x expected %h actual %h", $time, want.pos_x, got.pos_x);
                    error_count++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $display("%0t: pos_y expected %h actual %h", $time, want.pos_y, got.pos_y);
                    error_count++;
                end
                if (got.pos_z !== want.pos_z) begin
                    $display("%0t: pos_z expected %h actual %h", $time, want.pos_z, got.pos_z);
                    error_count++;
                end
                if (got.vel_x !== want.vel_x) begin
                    $display("%0t: vel_x expected %h actual %h", $time, want.vel_x, got.vel_x);
                    error_count++;
                end
                if (got.vel_y !== want.vel_y) begin
                    $display("%0t: vel_y expected %h actual %h", $time, want.vel_y, got.vel_y);
                    error_count++;
                end
                if (got.vel_z !== want.vel_z) begin
                    $display("%0t: vel_z expected %h actual %h", $time, want.vel_z, got.vel_z);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Angle extremes, quadrant boundaries, out-of-range declination, field extremes.
    task automatic test_directed;
        t_catalog_entry e;
        logic [31:0] angles [10];
        angles = '{32'h0000_0000, 32'h1FFF_FFFF, 32'h2000_0000, 32'h4000_0000,
                   32'h8000_0000, 32'hC000_0000, 32'hDFFF_FFFF, 32'hFFFF_FFFF,
                   32'h6000_0000, 32'hA000_0000};
        for (int i = 0; i < 10; i++) begin
            e.right_ascension = angles[i];
            e.declination = angles[(i + 3) % 10];
            e.ra_rate = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            e.dec_rate = (i % 3) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            e.parallax = (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
            e.radial_velocity = (i % 4 < 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            send_entry(e);
        end
        // declination exactly at both poles and beyond them
        e = '0;
        e.parallax = 32'hFFFF_FFFF;
        e.radial_velocity = 32'h0001_0000;
        e.declination = 32'h4000_0000; send_entry(e);
        e.declination = 32'hC000_0000; send_entry(e);
        e.declination = 32'h7FFF_FFFF; send_entry(e);
        e.declination = 32'h8000_0000; send_entry(e);
        e.ra_rate = 32'h0100_0000; e.dec_rate = 32'hFF00_0000;
        e.declination = 32'h1000_0000; e.right_ascension = 32'h3000_0000;
        send_entry(e);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            // alternate stretches of steady flow with randomly idling ones
            if (i % 60 == 0) steady = ($urandom_range(0, 3) == 0);
            send_entry(random_entry());
        end
        steady = 1'b0;
    endtask

    // Sweep velocity_scale over its extremes, plus a write to an unmapped address.
    task automatic test_scale_settings;
        drain();
        write_reg(ADDR_SCALE, 32'd0);
        test_directed();
        test_random(200);
        drain();
        write_reg(ADDR_SCALE, 32'hFFFF_FFFF);
        test_directed();
        test_random(200);
        // hold off mid-phase until the pipeline is empty
        drain();
        test_random(50);
        drain();
        write_reg(ADDR_UNMAPPED, 32'h1234_5678);
        write_reg(ADDR_SCALE, $urandom);
        test_random(200);
        drain();
        write_reg(ADDR_SCALE, 32'd1382485);
        test_random(200);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        scale_k = c2cs_pkg::VELOCITY_SCALE_RST;
        error_count = 0; entries_sent = 0; states_seen = 0;
        steady = 1'b0; rx_hold = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(150);
        test_scale_settings();
        drain();

        $display("Sent %0d catalog entries, checked %0d state vectors over five scale settings,",
                 entries_sent, states_seen);
        $display("with quadrant edges, poles, wrapped declinations and saturating rates.");
        if (error_count == 0 && pending_states.size() == 0) begin
            $display("[catalog_to_cartesian_state] OK");
        end else begin
            $display("[catalog_to_cartesian_state] ERROR");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("[catalog_to_cartesian_state] ERROR");
        $finish;
    end

endmodule
